[rtl/vthc_pkg.sv]
package vthc_pkg;

    localparam int SAMPLE_WIDTH_DEF        = 16;
    localparam int RATIO_FRACTION_BITS_DEF = 16;

    localparam int              CFG_INDEX_W    = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_RANGE_LOW  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_RANGE_HIGH = 1'b1;

    localparam int RANGE_LOW_RESET  = 0;
    localparam int RANGE_HIGH_RESET = 32767;

    // hue in q8.8 degrees
    localparam int              HUE_W      = 16;
    localparam logic [HUE_W-1:0] HUE_SECTOR = 16'd15360;
    localparam logic [HUE_W-1:0] HUE_PAIR   = 16'd30720;
    localparam logic [HUE_W-1:0] HUE_THREE  = 16'd46080;
    localparam logic [HUE_W-1:0] HUE_FULL   = 16'd61440;

    // 255 / 15360 == 17 / 1024
    localparam int RAMP_MUL    = 17;
    localparam int RAMP_SHIFT  = 10;
    localparam int RAMP_PROD_W = HUE_W + 5;

    localparam int               CHAN_W    = 8;
    localparam logic [CHAN_W-1:0] CHAN_FULL = 8'd255;
    localparam logic [CHAN_W-1:0] CHAN_ZERO = 8'd0;

    localparam int                 SECTOR_W         = 3;
    localparam logic [SECTOR_W-1:0] SEC_RED_YELLOW   = 3'd0;
    localparam logic [SECTOR_W-1:0] SEC_YELLOW_GREEN = 3'd1;
    localparam logic [SECTOR_W-1:0] SEC_GREEN_CYAN   = 3'd2;
    localparam logic [SECTOR_W-1:0] SEC_CYAN_BLUE    = 3'd3;
    localparam logic [SECTOR_W-1:0] SEC_BLUE_MAGENTA = 3'd4;
    localparam logic [SECTOR_W-1:0] SEC_MAGENTA_RED  = 3'd5;

    typedef struct packed {
        logic valid;
        logic force_one;
        logic use_quot;
        logic invalid;
    } vthc_ctrl_t;

endpackage

[rtl/vthc_front.sv]
module vthc_front
    import vthc_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           valid_in,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic signed [SAMPLE_WIDTH-1:0] range_low,
    input  logic signed [SAMPLE_WIDTH-1:0] range_high,
    output vthc_ctrl_t                     ctrl_out,
    output logic        [SAMPLE_WIDTH-1:0] rem_out,
    output logic        [SAMPLE_WIDTH-1:0] den_out
);

    localparam int EXT_W = SAMPLE_WIDTH + 1;

    logic signed [EXT_W-1:0] lo_x;
    logic signed [EXT_W-1:0] hi_x;
    logic signed [EXT_W-1:0] s_x;
    logic signed [EXT_W-1:0] den_x;
    logic signed [EXT_W-1:0] diff_x;
    logic                    range_ok;
    logic                    at_low;
    logic                    at_high;

    vthc_ctrl_t              ctrl_next;
    vthc_ctrl_t              ctrl_reg;
    logic [SAMPLE_WIDTH-1:0] rem_reg;
    logic [SAMPLE_WIDTH-1:0] den_reg;

    always_comb
    begin
        lo_x     = EXT_W'(range_low);
        hi_x     = EXT_W'(range_high);
        s_x      = EXT_W'(sample);
        den_x    = hi_x - lo_x;
        diff_x   = s_x - lo_x;
        range_ok = hi_x > lo_x;
        at_low   = s_x <= lo_x;
        at_high  = s_x >= hi_x;

        ctrl_next.valid     = valid_in;
        ctrl_next.invalid   = !range_ok;
        ctrl_next.force_one = range_ok && !at_low && at_high;
        ctrl_next.use_quot  = range_ok && !at_low && !at_high;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= diff_x[SAMPLE_WIDTH-1:0];
        den_reg <= den_x[SAMPLE_WIDTH-1:0];
    end

    assign ctrl_out = ctrl_reg;
    assign rem_out  = rem_reg;
    assign den_out  = den_reg;

endmodule

[rtl/vthc_div_stage.sv]
module vthc_div_stage
    import vthc_pkg::*;
#(
    parameter int SAMPLE_WIDTH        = SAMPLE_WIDTH_DEF,
    parameter int RATIO_FRACTION_BITS = RATIO_FRACTION_BITS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  vthc_ctrl_t                     ctrl_in,
    input  logic [SAMPLE_WIDTH-1:0]        rem_in,
    input  logic [SAMPLE_WIDTH-1:0]        den_in,
    input  logic [RATIO_FRACTION_BITS-1:0] quot_in,
    output vthc_ctrl_t                     ctrl_out,
    output logic [SAMPLE_WIDTH-1:0]        rem_out,
    output logic [SAMPLE_WIDTH-1:0]        den_out,
    output logic [RATIO_FRACTION_BITS-1:0] quot_out
);

    logic [SAMPLE_WIDTH:0]          rem2;
    logic [SAMPLE_WIDTH:0]          den_x;
    logic [SAMPLE_WIDTH:0]          sub;
    logic                           ge;
    logic [SAMPLE_WIDTH-1:0]        rem_next;
    logic [RATIO_FRACTION_BITS-1:0] quot_next;

    vthc_ctrl_t                     ctrl_reg;
    logic [SAMPLE_WIDTH-1:0]        rem_reg;
    logic [SAMPLE_WIDTH-1:0]        den_reg;
    logic [RATIO_FRACTION_BITS-1:0] quot_reg;

    // one restoring quotient bit
    always_comb
    begin
        rem2      = {rem_in, 1'b0};
        den_x     = {1'b0, den_in};
        sub       = rem2 - den_x;
        ge        = rem2 >= den_x;
        rem_next  = ge ? sub[SAMPLE_WIDTH-1:0] : rem2[SAMPLE_WIDTH-1:0];
        quot_next = {quot_in[RATIO_FRACTION_BITS-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_in;
        quot_reg <= quot_next;
    end

    assign ctrl_out = ctrl_reg;
    assign rem_out  = rem_reg;
    assign den_out  = den_reg;
    assign quot_out = quot_reg;

endmodule

[rtl/vthc_hue.sv]
module vthc_hue
    import vthc_pkg::*;
#(
    parameter int RATIO_FRACTION_BITS = RATIO_FRACTION_BITS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  vthc_ctrl_t                     ctrl_in,
    input  logic [RATIO_FRACTION_BITS-1:0] quot_in,
    output vthc_ctrl_t                     ctrl_out,
    output logic [SECTOR_W-1:0]            sector_out,
    output logic [CHAN_W-1:0]              ramp_out
);

    localparam int                          RATIO_W   = RATIO_FRACTION_BITS + 1;
    localparam int                          PROD_W    = RATIO_W + HUE_W;
    localparam logic [RATIO_W-1:0]          RATIO_ONE = {1'b1, {RATIO_FRACTION_BITS{1'b0}}};

    logic [RATIO_W-1:0]     ratio;
    logic [RATIO_W-1:0]     inv_ratio;
    logic [PROD_W-1:0]      prod;
    logic [HUE_W-1:0]       hue_next;

    vthc_ctrl_t             ctrl_a_reg;
    logic [HUE_W-1:0]       hue_reg;

    logic [HUE_W-1:0]       t_pair;
    logic [HUE_W-1:0]       t_ramp;
    logic [RAMP_PROD_W-1:0] ramp_prod;
    logic [SECTOR_W-1:0]    sector_next;

    vthc_ctrl_t             ctrl_b_reg;
    logic [SECTOR_W-1:0]    sector_reg;
    logic [CHAN_W-1:0]      ramp_reg;

    // hue = 240 deg * (1 - ratio)
    always_comb
    begin
        priority if (ctrl_in.force_one)
        begin
            ratio = RATIO_ONE;
        end
        else if (ctrl_in.use_quot)
        begin
            ratio = {1'b0, quot_in};
        end
        else
        begin
            ratio = '0;
        end
        inv_ratio = RATIO_ONE - ratio;
        prod      = PROD_W'(inv_ratio) * PROD_W'(HUE_FULL);
        hue_next  = prod[RATIO_FRACTION_BITS +: HUE_W];
    end

    always_comb
    begin
        priority if (hue_reg < HUE_SECTOR)
        begin
            sector_next = SEC_RED_YELLOW;
        end
        else if (hue_reg < HUE_PAIR)
        begin
            sector_next = SEC_YELLOW_GREEN;
        end
        else if (hue_reg < HUE_THREE)
        begin
            sector_next = SEC_GREEN_CYAN;
        end
        else if (hue_reg < HUE_FULL)
        begin
            sector_next = SEC_CYAN_BLUE;
        end
        else
        begin
            sector_next = SEC_BLUE_MAGENTA;
        end
        t_pair    = (hue_reg >= HUE_PAIR) ? (hue_reg - HUE_PAIR) : hue_reg;
        t_ramp    = (t_pair < HUE_SECTOR) ? t_pair : (HUE_PAIR - t_pair);
        ramp_prod = RAMP_PROD_W'(t_ramp) * RAMP_PROD_W'(RAMP_MUL);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_a_reg <= '0;
            ctrl_b_reg <= '0;
        end
        else
        begin
            ctrl_a_reg <= ctrl_in;
            ctrl_b_reg <= ctrl_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        hue_reg    <= hue_next;
        sector_reg <= sector_next;
        ramp_reg   <= ramp_prod[RAMP_SHIFT +: CHAN_W];
    end

    assign ctrl_out   = ctrl_b_reg;
    assign sector_out = sector_reg;
    assign ramp_out   = ramp_reg;

endmodule

[rtl/value_to_heatmap_color_core.sv]
// transactions pass from start through the front, divider and hue stages to done
// throughput: one transaction per cycle, busy is held low
// the divider computes one quotient bit per pipeline stage
// results appear on done for one cycle; the receiver cannot stall
// reset clears all pipeline valid bits, range_low to 0 and range_high to 32767
module value_to_heatmap_color_core
    import vthc_pkg::*;
#(
    parameter int SAMPLE_WIDTH        = SAMPLE_WIDTH_DEF,
    parameter int RATIO_FRACTION_BITS = RATIO_FRACTION_BITS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic                           cfg_we,
    input  logic        [CFG_INDEX_W-1:0]  cfg_index,
    input  logic        [SAMPLE_WIDTH-1:0] cfg_data,
    output logic                           done,
    output logic        [CHAN_W-1:0]       red,
    output logic        [CHAN_W-1:0]       green,
    output logic        [CHAN_W-1:0]       blue,
    output logic                           range_invalid
);

    localparam int                       LATENCY  = RATIO_FRACTION_BITS + 4;
    localparam logic [SAMPLE_WIDTH-1:0]  LOW_RST  = SAMPLE_WIDTH'(RANGE_LOW_RESET);
    localparam logic [SAMPLE_WIDTH-1:0]  HIGH_RST = SAMPLE_WIDTH'(RANGE_HIGH_RESET);

    logic [SAMPLE_WIDTH-1:0] range_low_reg;
    logic [SAMPLE_WIDTH-1:0] range_high_reg;

    vthc_ctrl_t                     div_ctrl [0:RATIO_FRACTION_BITS];
    logic [SAMPLE_WIDTH-1:0]        div_rem  [0:RATIO_FRACTION_BITS];
    logic [SAMPLE_WIDTH-1:0]        div_den  [0:RATIO_FRACTION_BITS];
    logic [RATIO_FRACTION_BITS-1:0] div_quot [0:RATIO_FRACTION_BITS];

    vthc_ctrl_t          hue_ctrl;
    logic [SECTOR_W-1:0] hue_sector;
    logic [CHAN_W-1:0]   hue_ramp;

    logic [CHAN_W-1:0]   red_next;
    logic [CHAN_W-1:0]   green_next;
    logic [CHAN_W-1:0]   blue_next;

    logic                done_reg;
    logic [CHAN_W-1:0]   red_reg;
    logic [CHAN_W-1:0]   green_reg;
    logic [CHAN_W-1:0]   blue_reg;
    logic                invalid_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_low_reg  <= LOW_RST;
            range_high_reg <= HIGH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RANGE_LOW:  range_low_reg  <= cfg_data;
                REG_RANGE_HIGH: range_high_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    vthc_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid_in   (start && !busy),
        .sample     (sample),
        .range_low  ($signed(range_low_reg)),
        .range_high ($signed(range_high_reg)),
        .ctrl_out   (div_ctrl[0]),
        .rem_out    (div_rem[0]),
        .den_out    (div_den[0])
    );

    assign div_quot[0] = '0;

    for (genvar i = 0; i < RATIO_FRACTION_BITS; i++)
    begin : g_div
        vthc_div_stage #(
            .SAMPLE_WIDTH        (SAMPLE_WIDTH),
            .RATIO_FRACTION_BITS (RATIO_FRACTION_BITS)
        ) u_div_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl_in  (div_ctrl[i]),
            .rem_in   (div_rem[i]),
            .den_in   (div_den[i]),
            .quot_in  (div_quot[i]),
            .ctrl_out (div_ctrl[i+1]),
            .rem_out  (div_rem[i+1]),
            .den_out  (div_den[i+1]),
            .quot_out (div_quot[i+1])
        );
    end

    vthc_hue #(
        .RATIO_FRACTION_BITS (RATIO_FRACTION_BITS)
    ) u_hue (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl_in    (div_ctrl[RATIO_FRACTION_BITS]),
        .quot_in    (div_quot[RATIO_FRACTION_BITS]),
        .ctrl_out   (hue_ctrl),
        .sector_out (hue_sector),
        .ramp_out   (hue_ramp)
    );

    always_comb
    begin
        unique case (hue_sector)
            SEC_RED_YELLOW:
            begin
                red_next   = CHAN_FULL;
                green_next = hue_ramp;
                blue_next  = CHAN_ZERO;
            end
            SEC_YELLOW_GREEN:
            begin
                red_next   = hue_ramp;
                green_next = CHAN_FULL;
                blue_next  = CHAN_ZERO;
            end
            SEC_GREEN_CYAN:
            begin
                red_next   = CHAN_ZERO;
                green_next = CHAN_FULL;
                blue_next  = hue_ramp;
            end
            SEC_CYAN_BLUE:
            begin
                red_next   = CHAN_ZERO;
                green_next = hue_ramp;
                blue_next  = CHAN_FULL;
            end
            SEC_BLUE_MAGENTA:
            begin
                red_next   = hue_ramp;
                green_next = CHAN_ZERO;
                blue_next  = CHAN_FULL;
            end
            SEC_MAGENTA_RED:
            begin
                red_next   = CHAN_FULL;
                green_next = CHAN_ZERO;
                blue_next  = hue_ramp;
            end
            default:
            begin
                red_next   = CHAN_FULL;
                green_next = CHAN_ZERO;
                blue_next  = hue_ramp;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= hue_ctrl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        red_reg     <= red_next;
        green_reg   <= green_next;
        blue_reg    <= blue_next;
        invalid_reg <= hue_ctrl.invalid;
    end

    assign done          = done_reg;
    assign red           = red_reg;
    assign green         = green_reg;
    assign blue          = blue_reg;
    assign range_invalid = invalid_reg;

    // every accepted transaction comes out after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted transaction did not complete on time");

    // no result without a transaction accepted exactly one latency earlier
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(start && !busy, LATENCY) |-> !done)
        else $error("result without matching transaction");

    // an empty or reversed range gives pure blue
    a_invalid_blue: assert property (@(posedge clk) disable iff (!rst_n)
        (done && range_invalid) |->
            (red == CHAN_ZERO && green == CHAN_ZERO && blue == CHAN_FULL))
        else $error("invalid range not mapped to blue");

    // every colour has one full channel and one dark channel
    a_full_and_dark: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((red == CHAN_FULL || green == CHAN_FULL || blue == CHAN_FULL) &&
                  (red == CHAN_ZERO || green == CHAN_ZERO || blue == CHAN_ZERO)))
        else $error("colour lacks a full or a dark channel");

endmodule

[sim/heatmap_colour_checker.sv]
module heatmap_colour_checker
    import vthc_pkg::*;
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic signed [SAMPLE_WIDTH_DEF-1:0]  sample,
    input  logic                                cfg_we,
    input  logic        [CFG_INDEX_W-1:0]       cfg_index,
    input  logic        [SAMPLE_WIDTH_DEF-1:0]  cfg_data,
    input  logic                                done,
    input  logic        [CHAN_W-1:0]            red,
    input  logic        [CHAN_W-1:0]            green,
    input  logic        [CHAN_W-1:0]            blue,
    input  logic                                range_invalid,
    output int unsigned                         fail_count,
    output int unsigned                         outstanding,
    output int unsigned                         sample_count,
    output int unsigned                         invalid_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SW  = SAMPLE_WIDTH_DEF;
    localparam int RFB = RATIO_FRACTION_BITS_DEF;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              invalid;
    } colour_t;

    logic signed [SW-1:0] range_lo;
    logic signed [SW-1:0] range_hi;
    colour_t              colour_q[$];
    int unsigned          result_count;

    // ratio, hue and sector mapping in fixed point
    function automatic colour_t heat_colour(input logic signed [SW-1:0] s,
                                            input logic signed [SW-1:0] lo,
                                            input logic signed [SW-1:0] hi);
        logic [RFB:0]    ratio;
        logic [SW:0]     span;
        logic [SW:0]     offset;
        logic [47:0]     quot;
        logic [47:0]     hue_wide;
        logic [HUE_W-1:0] hue;
        logic [HUE_W-1:0] pos;
        logic [CHAN_W-1:0] ramp;
        logic [SECTOR_W-1:0] sector;
        colour_t         c;
        ratio   = '0;
        c       = '0;
        if (hi > lo)
        begin
            span = {hi[SW-1], hi} - {lo[SW-1], lo};
            if (s <= lo)
                ratio = '0;
            else if (s >= hi)
                ratio = (RFB+1)'(1) << RFB;
            else
            begin
                offset = {s[SW-1], s} - {lo[SW-1], lo};
                quot   = (48'(offset) << RFB) / 48'(span);
                ratio  = quot[RFB:0];
            end
        end
        else
            c.invalid = 1'b1;
        hue_wide = 48'(HUE_FULL) * ((48'd1 << RFB) - 48'(ratio));
        hue_wide = hue_wide >> RFB;
        hue      = hue_wide[HUE_W-1:0];
        pos      = hue % HUE_PAIR;
        if (pos < HUE_SECTOR)
            ramp = CHAN_W'((32'(pos) * 255) / 32'(HUE_SECTOR));
        else
            ramp = CHAN_W'((32'(HUE_PAIR - pos) * 255) / 32'(HUE_SECTOR));
        sector = SECTOR_W'(hue / HUE_SECTOR);
        case (sector)
            SEC_RED_YELLOW:   begin c.red = CHAN_FULL; c.green = ramp;      c.blue = CHAN_ZERO; end
            SEC_YELLOW_GREEN: begin c.red = ramp;      c.green = CHAN_FULL; c.blue = CHAN_ZERO; end
            SEC_GREEN_CYAN:   begin c.red = CHAN_ZERO; c.green = CHAN_FULL; c.blue = ramp;      end
            SEC_CYAN_BLUE:    begin c.red = CHAN_ZERO; c.green = ramp;      c.blue = CHAN_FULL; end
            SEC_BLUE_MAGENTA: begin c.red = ramp;      c.green = CHAN_ZERO; c.blue = CHAN_FULL; end
            default:          begin c.red = CHAN_FULL; c.green = CHAN_ZERO; c.blue = ramp;      end
        endcase
        return c;
    endfunction

    task automatic report_mismatch(input string note);
        $display("[%0t] mismatch: %s", $realtime, note);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        colour_t want;
        if (!rst_n)
        begin
            range_lo      = SW'(RANGE_LOW_RESET);
            range_hi      = SW'(RANGE_HIGH_RESET);
            colour_q.delete();
            fail_count    = 0;
            sample_count  = 0;
            result_count  = 0;
            invalid_count = 0;
            outstanding  <= 0;
        end
        else
        begin
            if (done)
            begin
                result_count++;
                if (colour_q.size() == 0)
                    report_mismatch($sformatf("result %0d with nothing expected (%0d,%0d,%0d,%0b)",
                                              result_count, red, green, blue, range_invalid));
                else
                begin
                    want = colour_q.pop_front();
                    if (red !== want.red)
                        report_mismatch($sformatf("transaction %0d red %0d, expected %0d",
                                                  result_count, red, want.red));
                    if (green !== want.green)
                        report_mismatch($sformatf("transaction %0d green %0d, expected %0d",
                                                  result_count, green, want.green));
                    if (blue !== want.blue)
                        report_mismatch($sformatf("transaction %0d blue %0d, expected %0d",
                                                  result_count, blue, want.blue));
                    if (range_invalid !== want.invalid)
                        report_mismatch($sformatf("transaction %0d range_invalid %0b, expected %0b",
                                                  result_count, range_invalid, want.invalid));
                    if (want.invalid)
                        invalid_count++;
                end
            end
            if (start && !busy)
            begin
                colour_q.push_back(heat_colour(sample, range_lo, range_hi));
                sample_count++;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_RANGE_LOW:  range_lo = cfg_data;
                    REG_RANGE_HIGH: range_hi = cfg_data;
                    default: ;
                endcase
            end
            outstanding <= colour_q.size();
        end
    end

endmodule

[sim/tb_value_to_heatmap_color_core.sv]
module tb_value_to_heatmap_color_core;
    import vthc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SW          = SAMPLE_WIDTH_DEF;
    localparam int STALL_LIMIT = 4000;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic signed [SW-1:0]   sample;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [SW-1:0]          cfg_data;
    logic                   done;
    logic [CHAN_W-1:0]      red;
    logic [CHAN_W-1:0]      green;
    logic [CHAN_W-1:0]      blue;
    logic                   range_invalid;

    int unsigned fail_count;
    int unsigned outstanding;
    int unsigned sample_count;
    int unsigned invalid_count;
    int unsigned range_settings;
    int unsigned quiet_cycles;

    value_to_heatmap_color_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .sample        (sample),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .done          (done),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .range_invalid (range_invalid)
    );

    heatmap_colour_checker u_colour_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .sample        (sample),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .done          (done),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .range_invalid (range_invalid),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .sample_count  (sample_count),
        .invalid_count (invalid_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("value_to_heatmap_color_core regression: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic load_range(input int lo, input int hi);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= REG_RANGE_LOW;
        cfg_data  <= SW'(lo);
        @(posedge clk);
        cfg_index <= REG_RANGE_HIGH;
        cfg_data  <= SW'(hi);
        @(posedge clk);
        cfg_we    <= 1'b0;
        range_settings++;
    endtask

    task automatic feed_sample(input logic signed [SW-1:0] v, input int idle_pct);
        while (int'($urandom_range(99)) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start  <= 1'b1;
        sample <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    function automatic logic signed [SW-1:0] pick_sample(input int lo, input int hi);
        int v;
        if (hi <= lo)
            v = int'($urandom_range(65535)) - 32768;
        else
            case ($urandom_range(7))
                0:       v = int'($urandom_range(65535)) - 32768;
                1:       v = lo;
                2:       v = hi;
                3:       v = lo - 4 + int'($urandom_range(8));
                4:       v = hi - 4 + int'($urandom_range(8));
                default: v = lo + int'($urandom_range(hi - lo));
            endcase
        if (v < -32768)
            v = -32768;
        if (v > 32767)
            v = 32767;
        return SW'(v);
    endfunction

    int reset_samples[14] = '{-32768, -1, 0, 1, 8191, 8192, 16383, 16384,
                              24575, 24576, 32766, 32767, 21845, -21846};
    int phase_lo[8]       = '{-32768, -100, 32767, -32768, 0, 0, 32766, 0};
    int phase_hi[8]       = '{32767, 100, -32768, -32767, 1, 0, 32767, 0};
    int phase_idle[8]     = '{0, 87, 9, 0, 87, 9, 0, 87};

    initial
    begin
        int lo;
        int hi;
        start          <= 1'b0;
        sample         <= '0;
        cfg_we         <= 1'b0;
        cfg_index      <= REG_RANGE_LOW;
        cfg_data       <= '0;
        rst_n          <= 1'b0;
        range_settings  = 1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sector boundaries, clamps and bit patterns under the reset range
        foreach (reset_samples[i])
            feed_sample(SW'(reset_samples[i]), 0);

        // full span
        load_range(-32768, 32767);
        feed_sample(SW'(-32768), 0);
        feed_sample(SW'(32767), 0);
        feed_sample(SW'(0), 0);
        feed_sample(SW'(-1), 0);

        // empty range
        load_range(7, 7);
        feed_sample(SW'(7), 0);
        feed_sample(SW'(-32768), 0);
        feed_sample(SW'(32767), 0);

        // reversed range
        load_range(100, -100);
        feed_sample(SW'(0), 0);
        feed_sample(SW'(100), 0);

        for (int p = 0; p < 8; p++)
        begin
            lo = phase_lo[p];
            hi = phase_hi[p];
            if (p == 5)
            begin
                lo = int'($urandom_range(60000)) - 32768;
                hi = lo + int'($urandom_range(200));
            end
            else if (p == 7)
            begin
                lo = int'($urandom_range(65535)) - 32768;
                hi = int'($urandom_range(65535)) - 32768;
            end
            load_range(lo, hi);
            repeat (47)
                feed_sample(pick_sample(lo, hi), phase_idle[p]);
        end

        wait_drained();
        repeat (RATIO_FRACTION_BITS_DEF + 8) @(posedge clk);

        $display("covered %0d samples over %0d range settings, %0d with the range flagged invalid",
                 sample_count, range_settings, invalid_count);
        if (fail_count == 0)
            $display("value_to_heatmap_color_core regression: pass");
        else
            $display("value_to_heatmap_color_core regression: fail");
        $finish;
    end

endmodule
